### hdl/tbsw_pkg.sv
// Package for the time-binned sliding window unit.
// Field widths, register indexes, operation codes and reset values.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package tbsw_pkg;

  // Item field widths
  localparam int TIME_W   = 64;
  localparam int ADC_W    = 32;
  localparam int SUM_W    = 38;
  localparam int COUNT_W  = 6;
  localparam int WLEN_W   = 32;
  localparam int FILL_W   = 6;

  // Configuration port
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_WINDOW_LENGTH = 1'b0;
  localparam reg_idx_t REG_FILL_LIMIT    = 1'b1;

  // Operation codes
  typedef logic op_t;

  localparam op_t OP_APPEND = 1'b0;
  localparam op_t OP_SLIDE  = 1'b1;

  // Register reset values
  localparam logic [WLEN_W-1:0] WLEN_RESET = 32'd20000;
  localparam logic [FILL_W-1:0] FILL_RESET = 6'd20;

  // Default sizing
  localparam int DEPTH_DEFAULT     = 32;
  localparam int BIN_TICKS_DEFAULT = 1000;

endpackage

### hdl/tbsw_if.sv
// Channel interfaces of the time-binned sliding window unit.
// Depends on tbsw_pkg for field widths.
`timescale 1ns / 1ps

// Input items: one bin and the operation to apply
interface tbsw_item_if;
  logic                         valid;
  logic                         ready;
  tbsw_pkg::op_t                operation;
  logic [tbsw_pkg::TIME_W-1:0]  bin_start;
  logic [tbsw_pkg::ADC_W-1:0]   bin_adc;

  modport source (output valid, operation, bin_start, bin_adc, input ready);
  modport sink   (input valid, operation, bin_start, bin_adc, output ready);
endinterface

// Result items: window summary after each input item
interface tbsw_res_if;
  logic                         valid;
  logic                         ready;
  logic [tbsw_pkg::SUM_W-1:0]   window_sum;
  logic [tbsw_pkg::COUNT_W-1:0] num_bins;
  logic                         window_cleared;
  logic [tbsw_pkg::TIME_W-1:0]  window_start;
  logic                         store_dropped;

  modport source (output valid, window_sum, num_bins, window_cleared, window_start,
                  store_dropped, input ready);
  modport sink   (input valid, window_sum, num_bins, window_cleared, window_start,
                  store_dropped, output ready);
endinterface

### hdl/tbsw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tbsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/time_binned_sliding_window_unit.sv
// Time-binned sliding window unit, top level.
// Depends on tbsw_pkg, tbsw_item_if / tbsw_res_if and tbsw_ram.
//
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   operation, bin_start, bin_adc
// res       out  valid/ready   window_sum, num_bins, window_cleared, window_start,
//                              store_dropped
// cfg       in   cfg_we        cfg_index, cfg_data (write only)
//
// One item at a time. Append: store the bin. Slide on an empty window: restart at
// the bin's time. Slide otherwise: take the item, scan the held bins for age, evict
// the aged-out count of bins from the oldest end, read the newest bin, add the fill
// bins, then store; the scan and the eviction walk the bin memories one entry per
// cycle. Synchronous active-high reset empties the window; bin memories need no
// clearing. A stalled result holds in the output register while the next item is
// already taken in.
`timescale 1ns / 1ps

module time_binned_sliding_window_unit #(
  parameter int DEPTH     = tbsw_pkg::DEPTH_DEFAULT,
  parameter int BIN_TICKS = tbsw_pkg::BIN_TICKS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  tbsw_item_if.sink                     item,
  tbsw_res_if.source                    res,
  input  logic                          cfg_we,
  input  tbsw_pkg::reg_idx_t            cfg_index,
  input  logic [tbsw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tbsw_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = $clog2((DEPTH + 2) * BIN_TICKS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DROP   = 8'b0000_0100,
    S_NEWEST = 8'b0000_1000,
    S_GAP    = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_STORE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // Ring slot of the entry off places after base
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  state_t              state;
  logic [TIME_W-1:0]   t_r;
  logic [ADC_W-1:0]    adc_r;
  logic                cleared_r;
  logic                dropped_r;

  logic [CW-1:0]       held;
  logic [PW-1:0]       oldest;
  logic [SUM_W-1:0]    sum;
  logic [TIME_W-1:0]   restart;
  logic [WLEN_W-1:0]   wlen;
  logic [FILL_W-1:0]   fill_lim;

  logic [CW-1:0]       walk_idx;
  logic                rd_pend;
  logic [CW-1:0]       evict_cnt;
  logic [TIME_W-1:0]   last;
  logic [TIME_W-1:0]   last_next;
  logic [TIME_W-1:0]   gap;
  logic [KW-1:0]       kb;
  logic [KW-1:0]       thr;
  logic                fill_go;
  logic                has_room;

  logic                out_valid;
  logic [SUM_W-1:0]    out_sum;
  logic [COUNT_W-1:0]  out_count;
  logic                out_cleared;
  logic [TIME_W-1:0]   out_start;
  logic                out_dropped;

  logic                mem_we;
  logic [PW-1:0]       mem_waddr;
  logic [TIME_W-1:0]   time_wdata;
  logic [ADC_W-1:0]    adc_wdata;
  logic [PW-1:0]       time_raddr;
  logic [PW-1:0]       adc_raddr;
  logic [TIME_W-1:0]   time_rdata;
  logic [ADC_W-1:0]    adc_rdata;
  logic [TIME_W-1:0]   age;

  // Bin storage
  tbsw_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (time_wdata),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  tbsw_ram #(.WIDTH(ADC_W), .DEPTH(DEPTH)) u_adc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (adc_wdata),
    .raddr (adc_raddr),
    .rdata (adc_rdata)
  );

  // Gap fill test: another fill bin fits below the spacing, the limit and the depth
  assign has_room  = held < CW'(DEPTH);
  assign fill_go   = (gap >= TIME_W'(thr)) && (TIME_W'(held) < TIME_W'(fill_lim)) && has_room;
  assign last_next = last + TIME_W'(kb);
  assign age       = t_r - time_rdata;

  // Memory ports
  always_comb begin
    mem_we     = ((state == S_FILL) && fill_go) || ((state == S_STORE) && has_room);
    mem_waddr  = slot_of(oldest, held);
    time_wdata = (state == S_FILL) ? last_next : t_r;
    adc_wdata  = (state == S_FILL) ? '0 : adc_r;
    time_raddr = (state == S_SCAN) ? slot_of(oldest, walk_idx) : slot_of(oldest, held - CW'(1));
    adc_raddr  = slot_of(oldest, walk_idx);
  end

  assign item.ready = (state == S_IDLE);

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      held    <= '0;
      oldest  <= '0;
      sum     <= '0;
      restart <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            t_r       <= item.bin_start;
            adc_r     <= item.bin_adc;
            cleared_r <= 1'b0;
            dropped_r <= 1'b0;
            walk_idx  <= '0;
            evict_cnt <= '0;
            rd_pend   <= 1'b0;
            if (item.operation == OP_APPEND) begin
              state <= S_STORE;
            end else if (held == '0) begin
              // Nothing held: restart at this bin's time
              restart   <= item.bin_start;
              oldest    <= '0;
              sum       <= '0;
              cleared_r <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Count every held bin that has aged out
          if (rd_pend && (age >= TIME_W'(wlen))) begin
            evict_cnt <= evict_cnt + CW'(1);
          end
          if (walk_idx < held) begin
            walk_idx <= walk_idx + CW'(1);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              walk_idx <= '0;
              state    <= S_DROP;
            end
          end
        end
        S_DROP: begin
          // Remove that many bins from the oldest end
          if (rd_pend) begin
            sum <= sum - SUM_W'(adc_rdata);
          end
          if (walk_idx < evict_cnt) begin
            walk_idx <= walk_idx + CW'(1);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              if (held == evict_cnt) begin
                restart   <= t_r;
                oldest    <= '0;
                held      <= '0;
                sum       <= '0;
                cleared_r <= 1'b1;
                state     <= S_DONE;
              end else begin
                oldest <= slot_of(oldest, evict_cnt);
                held   <= held - evict_cnt;
                state  <= S_NEWEST;
              end
            end
          end
        end
        S_NEWEST: begin
          state <= S_GAP;
        end
        S_GAP: begin
          last  <= time_rdata;
          gap   <= t_r - time_rdata;
          kb    <= KW'(BIN_TICKS);
          thr   <= KW'(2 * BIN_TICKS);
          state <= S_FILL;
        end
        S_FILL: begin
          // Fill bin k starts k spacings after the previous one
          if (fill_go) begin
            held <= held + CW'(1);
            last <= last_next;
            kb   <= kb + KW'(BIN_TICKS);
            thr  <= thr + KW'(BIN_TICKS);
          end else begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (has_room) begin
            held <= held + CW'(1);
            sum  <= sum + SUM_W'(adc_r);
          end else begin
            dropped_r <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || res.ready)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || res.ready)) begin
      out_sum     <= sum;
      out_count   <= COUNT_W'(held);
      out_cleared <= cleared_r;
      out_start   <= restart;
      out_dropped <= dropped_r;
    end
  end

  assign res.valid          = out_valid;
  assign res.window_sum     = out_sum;
  assign res.num_bins       = out_count;
  assign res.window_cleared = out_cleared;
  assign res.window_start   = out_start;
  assign res.store_dropped  = out_dropped;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen     <= WLEN_RESET;
      fill_lim <= FILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: wlen     <= cfg_data[WLEN_W-1:0];
        REG_FILL_LIMIT:    fill_lim <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // Bin count never passes the ring depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(DEPTH))
    else $error("held bin count exceeds depth");

  // An empty window carries a zero sum
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (held == '0) |-> (sum == '0))
    else $error("empty window with nonzero sum");

  // A restart reports an empty window
  a_cleared_empty: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.window_cleared |-> (res.num_bins == '0) && (res.window_sum == '0))
    else $error("cleared window reported with bins");

  // A dropped bin means the window was full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.store_dropped |-> (res.num_bins == COUNT_W'(DEPTH)))
    else $error("bin dropped while window not full");

  // Only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second item taken while one is in flight");
`endif

endmodule
